// ----- rtl/sarl_pkg.sv -----
// Shared types and constants for the symbol address range lookup block.
package sarl_pkg;

  localparam int ADDR_W      = 32;
  localparam int SLOT_W      = 10;
  localparam int COUNT_W     = 11;
  localparam int INFO_W      = 8;
  localparam int IN_DATA_W   = 152;
  localparam int OUT_DATA_W  = 48;
  localparam int CFG_INDEX_W = 1;

  localparam logic [3:0] FUNC_TYPE = 4'h2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_STRING_BASE  = 1'b1;

  // One symbol table entry as held in the table memory.
  typedef struct packed {
    logic              is_func;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] name_off;
  } sym_entry_t;

endpackage

// ----- rtl/symbol_address_range_lookup.sv -----
// Symbol address range lookup: table memory, scan sequencer and result register.
// A load transaction writes its entry straight into the table. A lookup scans from slot 0 to
// the first matching slot, else through min(symbol_count, TABLE_DEPTH) slots (none for a
// zero count); the table memory's single read port scans one entry per cycle.
// rst_n is synchronous and active low; it clears control state and the configuration registers.
// The table has no reset and needs no clearing pass.
module symbol_address_range_lookup #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sarl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sarl_pkg::ADDR_W-1:0]         cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // entry_index[9:0], entry_start[41:10], entry_size[73:42], entry_info[81:74],
  // entry_name_offset[113:82], query_address[145:114], zero fill[151:146]
  input  logic [sarl_pkg::IN_DATA_W-1:0]      in_tdata,
  // command[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // found[0], name_address[32:1], matched_index[42:33], zero fill[47:43]
  output logic [sarl_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import sarl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PUT} state_t;

  // Input fields.
  logic [SLOT_W-1:0] entry_index;
  logic [ADDR_W-1:0] entry_start, entry_size, entry_name_offset, query_address;
  logic [INFO_W-1:0] entry_info;

  assign entry_index       = in_tdata[9:0];
  assign entry_start       = in_tdata[41:10];
  assign entry_size        = in_tdata[73:42];
  assign entry_info        = in_tdata[81:74];
  assign entry_name_offset = in_tdata[113:82];
  assign query_address     = in_tdata[145:114];

  // Configuration registers.
  logic [COUNT_W-1:0] symbol_count_r;
  logic [ADDR_W-1:0]  string_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_count_r <= '0;
      string_base_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYMBOL_COUNT: symbol_count_r <= cfg_wdata[COUNT_W-1:0];
        REG_STRING_BASE:  string_base_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake and control.
  state_t          state_r;
  logic            in_acc;
  logic            is_lookup;
  logic [CW-1:0]   limit_r;
  logic [CW-1:0]   issue_r;
  logic [CW-1:0]   rd_idx_r;
  logic            rd_vld_r;
  logic [ADDR_W-1:0] addr_r;
  logic            found_r;
  logic [CW-1:0]   hit_idx_r;
  logic [ADDR_W-1:0] hit_off_r;
  logic            out_vld_r;
  logic            out_found_r;
  logic [ADDR_W-1:0] out_name_r;
  logic [SLOT_W-1:0] out_idx_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_lookup = (in_tuser == CMD_LOOKUP);

  // Scan limit: the configured count saturated to the table depth.
  logic [31:0] count_ext;
  logic [31:0] limit_ext;
  logic [CW-1:0] limit_nxt;

  assign count_ext = 32'(symbol_count_r);
  assign limit_ext = (count_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : count_ext;
  assign limit_nxt = limit_ext[CW-1:0];

  // Table memory: one write port for loads, one registered read port for the scan.
  sym_entry_t mem [TABLE_DEPTH];
  sym_entry_t rd_data_r;
  logic       mem_we;
  logic [AW-1:0] wr_addr;
  logic [31:0] slot_ext;
  sym_entry_t wr_entry;
  logic       rd_en;

  assign slot_ext = 32'(entry_index);
  assign wr_addr  = slot_ext[AW-1:0];
  assign mem_we   = in_acc && (in_tuser == CMD_LOAD) && (slot_ext < 32'(TABLE_DEPTH));
  assign rd_en    = (state_r == S_SCAN) && (issue_r < limit_r);

  always_comb begin
    wr_entry.is_func  = (entry_info[3:0] == FUNC_TYPE);
    wr_entry.start    = entry_start;
    wr_entry.size     = entry_size;
    wr_entry.name_off = entry_name_offset;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[issue_r[AW-1:0]];
    end
  end

  logic hit;

  sarl_match u_match (
    .entry (rd_data_r),
    .addr  (addr_r),
    .hit   (hit)
  );

  logic          out_free;
  logic          put_fire;
  logic [31:0]   hit_idx_ext;

  assign out_free    = !out_vld_r || out_tready;
  assign put_fire    = (state_r == S_PUT) && out_free;
  assign hit_idx_ext = 32'(hit_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      found_r   <= 1'b0;
      issue_r   <= '0;
      limit_r   <= '0;
    end else begin
      if (put_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && is_lookup) begin
            addr_r   <= query_address;
            limit_r  <= limit_nxt;
            issue_r  <= '0;
            rd_vld_r <= 1'b0;
            found_r  <= 1'b0;
            state_r  <= (limit_nxt == '0) ? S_PUT : S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld_r <= rd_en;
          rd_idx_r <= issue_r;
          if (rd_en) begin
            issue_r <= issue_r + CW'(1);
          end
          if (rd_vld_r) begin
            if (hit) begin
              found_r   <= 1'b1;
              hit_idx_r <= rd_idx_r;
              hit_off_r <= rd_data_r.name_off;
              state_r   <= S_PUT;
            end else if (rd_idx_r == limit_r - CW'(1)) begin
              state_r <= S_PUT;
            end
          end
        end
        S_PUT: begin
          if (out_free) begin
            out_found_r <= found_r;
            out_name_r  <= found_r ? (string_base_r + hit_off_r) : '0;
            out_idx_r   <= found_r ? hit_idx_ext[SLOT_W-1:0] : '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, out_idx_r, out_name_r, out_found_r};

endmodule

// ----- rtl/sarl_match.sv -----
// Range compare unit: does one table entry cover the queried address.
module sarl_match (
  input  sarl_pkg::sym_entry_t        entry,
  input  logic [sarl_pkg::ADDR_W-1:0] addr,
  output logic                        hit
);
  import sarl_pkg::*;

  logic [ADDR_W-1:0] end_addr;

  // The end address wraps at 2^32, so a wrapping entry never matches.
  assign end_addr = entry.start + entry.size;
  assign hit      = entry.is_func && (addr >= entry.start) && (addr < end_addr);

endmodule

// ----- rtl/sarl_checker.sv -----
// Port-level checks for the symbol address range lookup, bound to the top level.
module sarl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sarl_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import sarl_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // A miss carries a zero name address and a zero slot.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[42:1] == '0)
    else $error("miss result carries nonzero fields");

  // A lookup transaction keeps the input side closed while the scan runs.
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_LOOKUP) |=> !in_tready)
    else $error("input accepted during a lookup");

  // A load transaction leaves the input side open for the next one.
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_LOAD) |=> in_tready)
    else $error("load did not finish in one cycle");

endmodule

bind symbol_address_range_lookup sarl_checker u_sarl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- verif/tb_symbol_address_range_lookup.sv -----
// Self-checking testbench for the symbol address range lookup block.
module tb_symbol_address_range_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import sarl_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_GOAL = 580;

  typedef struct {
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic [INFO_W-1:0] info;
    logic [ADDR_W-1:0] name_off;
    logic [ADDR_W-1:0] addr;
  } sym_cmd_t;

  typedef struct {
    logic              found;
    logic [ADDR_W-1:0] name_addr;
    logic [SLOT_W-1:0] slot;
  } sym_hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Local copy of the symbol table and registers. Every slot is loaded before
  // the first scan that can reach it, so zero defaults are never relied on.
  bit [ADDR_W-1:0] tbl_start [DEPTH];
  bit [ADDR_W-1:0] tbl_size  [DEPTH];
  bit [ADDR_W-1:0] tbl_name  [DEPTH];
  bit              tbl_func  [DEPTH];
  logic [COUNT_W-1:0] sym_count = '0;
  logic [ADDR_W-1:0]  str_base = '0;

  sym_cmd_t cmd_queue [$];
  sym_hit_t resolutions_due [$];

  sym_cmd_t in_cur;
  bit in_free;
  int in_gap = 0;
  int out_wait = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit hold_go = 1'b0;
  logic hold_on = 1'b0;
  sym_hit_t got, want;

  int err_count = 0;
  int n_loads = 0;
  int n_lookups = 0;
  int n_found = 0;
  int n_writes = 0;

  symbol_address_range_lookup #(.TABLE_DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    // entry_index, entry_start, entry_size, entry_info, entry_name_offset,
    // query_address, zero fill
    .in_tdata(in_tdata),
    // command
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // found, name_address, matched_index, zero fill
    .out_tdata(out_tdata)
  );

  always #2 clk = ~clk;

  // First function entry in index order whose range covers the address.
  function automatic sym_hit_t resolve_address(logic [ADDR_W-1:0] addr);
    sym_hit_t r;
    int lim;
    logic [ADDR_W-1:0] hi;
    r.found = 1'b0;
    r.name_addr = '0;
    r.slot = '0;
    lim = (sym_count > DEPTH) ? DEPTH : int'(sym_count);
    for (int i = 0; i < lim; i++) begin
      if (tbl_func[i]) begin
        hi = tbl_start[i] + tbl_size[i];
        if (addr >= tbl_start[i] && addr < hi) begin
          r.found = 1'b1;
          r.name_addr = str_base + tbl_name[i];
          r.slot = i[SLOT_W-1:0];
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic int draw_gap(int pct);
    return ($urandom_range(0, 99) < pct) ? $urandom_range(1, 15) : 0;
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 30;
      default: return 80;
    endcase
  endfunction

  function automatic sym_cmd_t mk_load(int slot, logic [ADDR_W-1:0] start,
                                       logic [ADDR_W-1:0] size, logic [INFO_W-1:0] info,
                                       logic [ADDR_W-1:0] name_off);
    sym_cmd_t it;
    it.cmd = CMD_LOAD;
    it.slot = slot[SLOT_W-1:0];
    it.start = start;
    it.size = size;
    it.info = info;
    it.name_off = name_off;
    it.addr = $urandom;
    return it;
  endfunction

  function automatic sym_cmd_t mk_lookup(logic [ADDR_W-1:0] addr);
    sym_cmd_t it;
    it.cmd = CMD_LOOKUP;
    it.slot = SLOT_W'($urandom);
    it.start = $urandom;
    it.size = $urandom;
    it.info = INFO_W'($urandom);
    it.name_off = $urandom;
    it.addr = addr;
    return it;
  endfunction

  // Random entry: starts cluster near other entries so ranges overlap, and
  // sizes include zero, exact top-of-space ends and wrapping ends.
  function automatic sym_cmd_t rand_entry(int slot);
    logic [ADDR_W-1:0] start, size;
    logic [3:0] kind;
    if ($urandom_range(0, 2) == 0)
      start = tbl_start[$urandom_range(0, 63)] + $urandom_range(0, 64);
    else
      start = $urandom;
    case ($urandom_range(0, 9))
      0: size = '0;
      1: size = $urandom;
      2: size = (~start) + 32'd1 + 32'($urandom_range(0, 64));
      3: size = ~start;
      default: size = $urandom_range(1, 4096);
    endcase
    kind = ($urandom_range(0, 9) < 6) ? FUNC_TYPE : 4'($urandom);
    return mk_load(slot, start, size, {4'($urandom), kind}, $urandom);
  endfunction

  // Mostly addresses at, inside or just past a loaded range; the rest random.
  function automatic sym_cmd_t rand_lookup(int lim);
    int s;
    logic [ADDR_W-1:0] addr;
    addr = $urandom;
    if (lim > 0 && $urandom_range(0, 9) < 7) begin
      s = $urandom_range(0, lim - 1);
      case ($urandom_range(0, 3))
        0: addr = tbl_start[s];
        1: addr = tbl_start[s] + tbl_size[s] - 32'd1;
        2: addr = tbl_start[s] + tbl_size[s];
        default: addr = tbl_start[s] + ((tbl_size[s] != 0) ? ($urandom % tbl_size[s]) : 0);
      endcase
    end
    return mk_lookup(addr);
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [ADDR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SYMBOL_COUNT)
      sym_count = val[COUNT_W-1:0];
    else
      str_base = val;
    n_writes++;
    @(posedge clk);
  endtask

  // Wait until every queued transaction is accepted and every lookup answered.
  task automatic settle();
    while (cmd_queue.size() != 0 || in_tvalid || resolutions_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      in_free = !in_tvalid;
      if (in_tvalid && in_tready) begin
        if (in_cur.cmd == CMD_LOAD) begin
          tbl_start[in_cur.slot] = in_cur.start;
          tbl_size[in_cur.slot] = in_cur.size;
          tbl_name[in_cur.slot] = in_cur.name_off;
          tbl_func[in_cur.slot] = (in_cur.info[3:0] == FUNC_TYPE);
          n_loads++;
        end else begin
          resolutions_due.push_back(resolve_address(in_cur.addr));
          n_lookups++;
        end
        in_free = 1'b1;
      end
      if (in_free) begin
        if (in_gap == 0 && cmd_queue.size() != 0) begin
          in_cur = cmd_queue.pop_front();
          in_tdata <= {6'b0, in_cur.addr, in_cur.name_off, in_cur.info, in_cur.size,
                       in_cur.start, in_cur.slot};
          in_tuser <= in_cur.cmd;
          in_tvalid <= 1'b1;
          in_gap = draw_gap(in_idle_pct);
        end else begin
          if (in_gap > 0) in_gap--;
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.found = out_tdata[0];
        got.name_addr = out_tdata[32:1];
        got.slot = out_tdata[42:33];
        if (resolutions_due.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("ERROR: unexpected result found=%b name=%h slot=%0d",
                     got.found, got.name_addr, got.slot);
        end else begin
          want = resolutions_due.pop_front();
          if (got.found !== want.found || got.name_addr !== want.name_addr ||
              got.slot !== want.slot) begin
            err_count++;
            if (err_count <= 10)
              $display("ERROR: expected found=%b name=%h slot=%0d, got found=%b name=%h slot=%0d",
                       want.found, want.name_addr, want.slot,
                       got.found, got.name_addr, got.slot);
          end
          if (want.found) n_found++;
        end
        out_wait = draw_gap(out_idle_pct);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_tready <= (out_wait == 0) && !hold_on;
    end
  end

  // Long receiver hold-off so that the block backs up and stalls its input.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int cnt, lim, n, slot, random_items, phase, sel;
    logic [ADDR_W-1:0] base;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset count of zero nothing is scanned and nothing matches.
    cmd_queue.push_back(mk_lookup(32'h0));
    cmd_queue.push_back(mk_lookup(32'hFFFF_FFFF));
    settle();

    // Fill the whole table so that any count is safe to scan.
    in_idle_pct = 20;
    out_idle_pct = 20;
    for (int s = 0; s < DEPTH; s++) cmd_queue.push_back(rand_entry(s));
    settle();

    write_reg(REG_SYMBOL_COUNT, 32'd8);
    write_reg(REG_STRING_BASE, 32'h0000_1000);
    cmd_queue.push_back(mk_load(0, 32'h100, 32'h10, 8'h21, 32'h11));        // not a function
    cmd_queue.push_back(mk_load(1, 32'h300, 32'h0, 8'h02, 32'h22));         // zero size
    cmd_queue.push_back(mk_load(2, 32'hFFFF_FFF0, 32'h20, 8'h12, 32'h33));  // wrapping end
    cmd_queue.push_back(mk_load(3, 32'h0, 32'h10, 8'hF2, 32'h44));
    cmd_queue.push_back(mk_load(4, 32'hFFFF_FF00, 32'hFF, 8'h02, 32'h55));
    cmd_queue.push_back(mk_load(5, 32'h8, 32'h100, 8'h02, 32'h66));         // overlaps slot 3
    cmd_queue.push_back(mk_load(6, 32'h100, 32'h10, 8'h02, 32'hFFFF_FFFF));
    cmd_queue.push_back(mk_load(7, 32'h200, 32'hFFFF_FFFF, 8'h02, 32'h0));
    cmd_queue.push_back(mk_lookup(32'h0));
    cmd_queue.push_back(mk_lookup(32'hF));
    cmd_queue.push_back(mk_lookup(32'h10));
    cmd_queue.push_back(mk_lookup(32'h107));
    cmd_queue.push_back(mk_lookup(32'h108));
    cmd_queue.push_back(mk_lookup(32'h110));
    cmd_queue.push_back(mk_lookup(32'h300));
    cmd_queue.push_back(mk_lookup(32'hFFFF_FFF8));
    cmd_queue.push_back(mk_lookup(32'hFFFF_FFFF));
    cmd_queue.push_back(mk_lookup(32'h250));
    cmd_queue.push_back(mk_lookup(32'h100));
    settle();

    // A count above the table depth scans the full table.
    write_reg(REG_SYMBOL_COUNT, 32'd2047);
    write_reg(REG_STRING_BASE, 32'hFFFF_FFFF);
    cmd_queue.push_back(mk_lookup(32'h105));
    cmd_queue.push_back(rand_lookup(DEPTH));
    settle();
    write_reg(REG_SYMBOL_COUNT, 32'd1024);
    cmd_queue.push_back(rand_lookup(DEPTH));
    cmd_queue.push_back(mk_lookup($urandom));
    settle();

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_GOAL) begin
      sel = $urandom_range(0, 19);
      if (sel < 2) cnt = 0;
      else if (sel < 14) cnt = $urandom_range(1, 32);
      else if (sel < 17) cnt = $urandom_range(33, 300);
      else if (sel < 18) cnt = DEPTH;
      else if (sel < 19) cnt = $urandom_range(DEPTH + 1, 2047);
      else cnt = 1;
      if (phase == 2) cnt = 4;
      case ($urandom_range(0, 3))
        0: base = '0;
        1: base = '1;
        default: base = $urandom;
      endcase
      write_reg(REG_SYMBOL_COUNT, 32'(cnt));
      write_reg(REG_STRING_BASE, base);
      lim = (cnt > DEPTH) ? DEPTH : cnt;
      n = (lim > 256) ? 6 : $urandom_range(20, 60);
      in_idle_pct = pick_idle();
      out_idle_pct = pick_idle();
      if (phase == 2) begin
        in_idle_pct = 0;
        n = 40;
        hold_go = 1'b1;
      end
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 99) < 35) begin
          if (lim > 0 && $urandom_range(0, 4) != 0)
            slot = $urandom_range(0, ((lim > 64) ? 64 : lim) - 1);
          else
            slot = $urandom_range(0, DEPTH - 1);
          cmd_queue.push_back(rand_entry(slot));
        end else begin
          cmd_queue.push_back(rand_lookup(lim));
        end
      end
      random_items += n;
      settle();
      phase++;
    end

    repeat (32) @(posedge clk);
    $display("Run covered %0d load and %0d lookup transactions; %0d lookups hit a symbol.",
             n_loads, n_lookups, n_found);
    $display("Register writes: %0d over %0d random table settings; errors: %0d.",
             n_writes, phase, err_count);
    if (err_count == 0 && resolutions_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
